[design/sha1_stream_hasher_assert.svh]
// Assertion macros shared by the hasher modules.
// Each expects clk and rst in scope and is disabled while rst is high.
`ifndef SHA1_STREAM_HASHER_ASSERT_SVH
`define SHA1_STREAM_HASHER_ASSERT_SVH

// Same-cycle implication.
`define SHA1SH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define SHA1SH_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[design/sha1sh_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package sha1sh_pkg;

  // Initial chaining values
  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hEFCDAB89;
  localparam logic [31:0] IV2 = 32'h98BADCFE;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hC3D2E1F0;

  // Round constants
  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam logic [5:0] FILL_LAST  = 6'd63;
  localparam logic [5:0] LEN_START  = 6'd56;
  localparam logic [6:0] ROUND_LAST = 7'd79;
  localparam logic [6:0] SCHED_FROM = 7'd16;
  localparam logic [6:0] PHASE1_AT  = 7'd20;
  localparam logic [6:0] PHASE2_AT  = 7'd40;
  localparam logic [6:0] PHASE3_AT  = 7'd60;
  localparam logic [2:0] WORD_LAST  = 3'd4;
  localparam logic [2:0] WORD_FIRST = 3'd0;

  typedef enum logic [1:0] {
    SEL_MSG  = 2'd0,
    SEL_PAD  = 2'd1,
    SEL_ZERO = 2'd2,
    SEL_LEN  = 2'd3
  } byte_sel_t;

  typedef enum logic [1:0] {
    PH_CH     = 2'd0,
    PH_PARITY = 2'd1,
    PH_MAJ    = 2'd2,
    PH_PARLATE = 2'd3
  } phase_t;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       byte_present;
    logic       end_of_message;
  } msg_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_item_t;

  // Controller to datapath
  typedef struct packed {
    logic      shift;      // push one byte into the block window
    byte_sel_t sel;        // source of that byte
    logic      count;      // add 8 to the bit count
    logic      load_work;  // a..e <= h0..h4
    logic      round;      // run one compression round
    logic      sched;      // round uses the expanded schedule word
    phase_t    phase;
    logic      add_chain;  // h += a..e
    logic      finish;     // digest <= h + a..e, reinit chain
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [5:0] fill;
    logic       out_busy;
  } dp_sts_t;

endpackage

`default_nettype wire

[design/sha1sh_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "sha1_stream_hasher_assert.svh"

module sha1sh_datapath (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic [7:0]             msg_byte,
  input  wire sha1sh_pkg::dp_cmd_t    cmd,
  output sha1sh_pkg::dp_sts_t         sts,
  output sha1sh_pkg::digest_item_t    digest,
  output logic                        digest_valid,
  input  wire logic                   digest_ready
);

  // Block window: bytes shift in at the bottom, first byte ends up on top.
  // During compression the same register is the 16-word schedule window.
  logic [511:0] win;
  logic [31:0]  a, b, c, d, e;
  logic [31:0]  h0, h1, h2, h3, h4;
  logic [63:0]  bl;
  logic [5:0]   fill;
  logic [159:0] dg;
  logic [2:0]   out_idx;

  logic [7:0]  in_byte;
  logic [7:0]  len_byte;
  logic [31:0] w0, w2, w8, w13, w_x, w_t;
  logic [31:0] f, k, t;

  assign len_byte = 8'(bl >> {~fill[2:0], 3'b000});

  always_comb begin
    unique case (cmd.sel)
      sha1sh_pkg::SEL_MSG:  in_byte = msg_byte;
      sha1sh_pkg::SEL_PAD:  in_byte = sha1sh_pkg::PAD_BYTE;
      sha1sh_pkg::SEL_ZERO: in_byte = 8'h00;
      sha1sh_pkg::SEL_LEN:  in_byte = len_byte;
      default:              in_byte = 8'h00;
    endcase
  end

  assign w0  = win[511:480];
  assign w2  = win[447:416];
  assign w8  = win[255:224];
  assign w13 = win[95:64];
  assign w_x = w13 ^ w8 ^ w2 ^ w0;
  assign w_t = cmd.sched ? {w_x[30:0], w_x[31]} : w0;

  always_comb begin
    unique case (cmd.phase)
      sha1sh_pkg::PH_CH: begin
        f = (b & c) | (~b & d);
        k = sha1sh_pkg::K0;
      end
      sha1sh_pkg::PH_PARITY: begin
        f = b ^ c ^ d;
        k = sha1sh_pkg::K1;
      end
      sha1sh_pkg::PH_MAJ: begin
        f = (b & c) | (b & d) | (c & d);
        k = sha1sh_pkg::K2;
      end
      sha1sh_pkg::PH_PARLATE: begin
        f = b ^ c ^ d;
        k = sha1sh_pkg::K3;
      end
      default: begin
        f = b ^ c ^ d;
        k = sha1sh_pkg::K3;
      end
    endcase
  end

  assign t = {a[26:0], a[31:27]} + f + e + k + w_t;

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      win <= {win[503:0], in_byte};
    end else if (cmd.round) begin
      win <= {win[479:0], w_t};
    end

    if (cmd.load_work) begin
      a <= h0;
      b <= h1;
      c <= h2;
      d <= h3;
      e <= h4;
    end else if (cmd.round) begin
      a <= t;
      b <= a;
      c <= {b[1:0], b[31:2]};
      d <= c;
      e <= d;
    end

    if (cmd.finish) begin
      dg <= {h0 + a, h1 + b, h2 + c, h3 + d, h4 + e};
    end else if (digest_valid && digest_ready) begin
      dg <= {dg[127:0], 32'h0};
    end
  end

  // Control and chaining state
  always_ff @(posedge clk) begin
    if (rst) begin
      h0           <= sha1sh_pkg::IV0;
      h1           <= sha1sh_pkg::IV1;
      h2           <= sha1sh_pkg::IV2;
      h3           <= sha1sh_pkg::IV3;
      h4           <= sha1sh_pkg::IV4;
      bl           <= 64'd0;
      fill         <= 6'd0;
      digest_valid <= 1'b0;
      out_idx      <= sha1sh_pkg::WORD_FIRST;
    end else begin
      if (cmd.shift) begin
        fill <= fill + 6'd1;
      end
      if (cmd.finish) begin
        h0 <= sha1sh_pkg::IV0;
        h1 <= sha1sh_pkg::IV1;
        h2 <= sha1sh_pkg::IV2;
        h3 <= sha1sh_pkg::IV3;
        h4 <= sha1sh_pkg::IV4;
        bl <= 64'd0;
      end else begin
        if (cmd.add_chain) begin
          h0 <= h0 + a;
          h1 <= h1 + b;
          h2 <= h2 + c;
          h3 <= h3 + d;
          h4 <= h4 + e;
        end
        if (cmd.count) begin
          bl <= bl + 64'd8;
        end
      end
      if (cmd.finish) begin
        digest_valid <= 1'b1;
        out_idx      <= sha1sh_pkg::WORD_FIRST;
      end else if (digest_valid && digest_ready) begin
        out_idx <= out_idx + 3'd1;
        if (out_idx == sha1sh_pkg::WORD_LAST) begin
          digest_valid <= 1'b0;
        end
      end
    end
  end

  assign sts.fill     = fill;
  assign sts.out_busy = digest_valid;

  assign digest.digest_word = dg[159:128];
  assign digest.word_index  = out_idx;
  assign digest.last_word   = (out_idx == sha1sh_pkg::WORD_LAST);

  `SHA1SH_ASSERT_NXT(a_finish_starts_out, cmd.finish,
                     digest_valid && out_idx == sha1sh_pkg::WORD_FIRST,
                     "digest transfer did not start at word 0")
  `SHA1SH_ASSERT_IMP(a_shift_round_excl, cmd.shift, !cmd.round,
                     "byte shift collides with a compression round")
  `SHA1SH_ASSERT_IMP(a_out_idx_range, digest_valid, out_idx <= sha1sh_pkg::WORD_LAST,
                     "digest word index out of range")

endmodule

`default_nettype wire

[design/sha1sh_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "sha1_stream_hasher_assert.svh"

module sha1sh_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 msg_valid,
  output logic                      msg_ready,
  input  wire logic                 byte_present,
  input  wire logic                 end_of_message,
  input  wire sha1sh_pkg::dp_sts_t  sts,
  output sha1sh_pkg::dp_cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RND  = 4'b0010,
    S_ADD  = 4'b0100,
    S_PAD  = 4'b1000
  } state_t;

  state_t     state, state_next;
  logic [6:0] rnd, rnd_next;
  logic       padding, padding_next;   // message closed, pad bytes pending
  logic       pad_first, pad_first_next; // next pad byte is 0x80
  logic       len_ok, len_ok_next;     // this block carries the length
  logic       last_blk, last_blk_next; // compression in flight is the final one

  always_comb begin
    state_next     = state;
    rnd_next       = rnd;
    padding_next   = padding;
    pad_first_next = pad_first;
    len_ok_next    = len_ok;
    last_blk_next  = last_blk;
    msg_ready      = 1'b0;
    cmd            = '0;

    if (rnd < sha1sh_pkg::PHASE1_AT) begin
      cmd.phase = sha1sh_pkg::PH_CH;
    end else if (rnd < sha1sh_pkg::PHASE2_AT) begin
      cmd.phase = sha1sh_pkg::PH_PARITY;
    end else if (rnd < sha1sh_pkg::PHASE3_AT) begin
      cmd.phase = sha1sh_pkg::PH_MAJ;
    end else begin
      cmd.phase = sha1sh_pkg::PH_PARLATE;
    end

    unique case (state)
      S_IDLE: begin
        msg_ready = 1'b1;
        if (msg_valid) begin
          cmd.shift = byte_present;
          cmd.sel   = sha1sh_pkg::SEL_MSG;
          cmd.count = byte_present;
          if (end_of_message) begin
            padding_next   = 1'b1;
            pad_first_next = 1'b1;
            len_ok_next    = 1'b0;
          end
          if (byte_present && sts.fill == sha1sh_pkg::FILL_LAST) begin
            cmd.load_work = 1'b1;
            last_blk_next = 1'b0;
            state_next    = S_RND;
          end else if (end_of_message) begin
            state_next = S_PAD;
          end
        end
      end
      S_PAD: begin
        cmd.shift      = 1'b1;
        pad_first_next = 1'b0;
        if (pad_first) begin
          cmd.sel     = sha1sh_pkg::SEL_PAD;
          len_ok_next = (sts.fill < sha1sh_pkg::LEN_START);
        end else if (len_ok && sts.fill >= sha1sh_pkg::LEN_START) begin
          cmd.sel = sha1sh_pkg::SEL_LEN;
        end else begin
          cmd.sel = sha1sh_pkg::SEL_ZERO;
        end
        if (sts.fill == sha1sh_pkg::FILL_LAST) begin
          cmd.load_work = 1'b1;
          last_blk_next = !pad_first && len_ok;
          state_next    = S_RND;
        end
      end
      S_RND: begin
        cmd.round = 1'b1;
        cmd.sched = (rnd >= sha1sh_pkg::SCHED_FROM);
        if (rnd == sha1sh_pkg::ROUND_LAST) begin
          rnd_next   = 7'd0;
          state_next = S_ADD;
        end else begin
          rnd_next = rnd + 7'd1;
        end
      end
      S_ADD: begin
        if (last_blk) begin
          // hold until the previous digest has fully drained
          if (!sts.out_busy) begin
            cmd.finish    = 1'b1;
            padding_next  = 1'b0;
            last_blk_next = 1'b0;
            state_next    = S_IDLE;
          end
        end else begin
          cmd.add_chain = 1'b1;
          if (padding) begin
            len_ok_next = 1'b1;
            state_next  = S_PAD;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rnd       <= 7'd0;
      padding   <= 1'b0;
      pad_first <= 1'b0;
      len_ok    <= 1'b0;
      last_blk  <= 1'b0;
    end else begin
      state     <= state_next;
      rnd       <= rnd_next;
      padding   <= padding_next;
      pad_first <= pad_first_next;
      len_ok    <= len_ok_next;
      last_blk  <= last_blk_next;
    end
  end

  `SHA1SH_ASSERT_NXT(a_full_block_compresses,
                     state == S_IDLE && msg_valid && byte_present &&
                     sts.fill == sha1sh_pkg::FILL_LAST,
                     state == S_RND, "full block did not start compression")
  `SHA1SH_ASSERT_IMP(a_finish_needs_free_out, cmd.finish, !sts.out_busy,
                     "digest overwritten before it drained")
  `SHA1SH_ASSERT_IMP(a_round_in_range, state == S_RND, rnd <= sha1sh_pkg::ROUND_LAST,
                     "round counter ran past the last round")

endmodule

`default_nettype wire

[design/sha1_stream_hasher.sv]
// SHA-1 stream hasher.
// msg channel (msg_valid/msg_ready, payload msg): one transfer per step, carrying
//   a message byte, a byte_present flag and an end_of_message flag.
// digest channel (digest_valid/digest_ready, payload digest): five transfers per
//   message, h0 first, word_index 0..4, last_word set on the fifth.
// Flow: each accepted present byte enters the block window; every 64th byte
//   starts a compression (80 rounds at one round per cycle in the shared round
//   unit, then the chaining add), during which msg_ready is low.
// Completion: after the closing transfer, the pad bytes shift in one per cycle
//   (64 minus the buffered byte count, or that plus 64 when fewer than 9 bytes
//   are free), each padded block is compressed in turn, and the first digest
//   word is valid the cycle after the final chaining add.
// The digest sits in its own output register, so the next message may stream in
//   while the digest drains; the final add of the next message waits until the
//   previous digest has been fully taken. A stalled receiver holds the current
//   word steady and only blocks input at that point.
// Reset (synchronous, rst high) loads the initial chaining words, clears the bit
//   count and byte fill, and drops digest_valid.
`timescale 1ns / 1ps
`default_nettype none

module sha1_stream_hasher (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    msg_valid,
  output logic                         msg_ready,
  input  wire sha1sh_pkg::msg_item_t   msg,
  output logic                         digest_valid,
  input  wire logic                    digest_ready,
  output sha1sh_pkg::digest_item_t     digest
);

  // command/status link between sequencer and datapath
  sha1sh_pkg::dp_cmd_t cmd;
  sha1sh_pkg::dp_sts_t sts;

  sha1sh_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .msg_valid      (msg_valid),
    .msg_ready      (msg_ready),
    .byte_present   (msg.byte_present),
    .end_of_message (msg.end_of_message),
    .sts            (sts),
    .cmd            (cmd)
  );

  sha1sh_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .msg_byte     (msg.msg_byte),
    .cmd          (cmd),
    .sts          (sts),
    .digest       (digest),
    .digest_valid (digest_valid),
    .digest_ready (digest_ready)
  );

endmodule

`default_nettype wire
